[hw/rtl/hsvrgb_pkg.sv]
// Shared constants and types for the HSV to RGBA pixel converter.
`default_nettype none

package hsvrgb_pkg;

    // Beat widths
    localparam int HUE_W       = 16;
    localparam int SV_W        = 18;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    // Clamped saturation / value, 0..65536
    localparam int UNIT_W = 17;
    localparam logic [UNIT_W-1:0] UNIT_ONE = 17'd65536;

    // Hue bias: multiple of 360 that makes every 16-bit hue positive
    localparam int HB_W = 17;
    localparam logic [HB_W:0] HUE_BIAS = 18'd33120;

    // Divide by 360: floor(h * 186414 / 2^26), exact for h < 2^17
    localparam logic [17:0] RECIP360    = 18'd186414;
    localparam int          RECIP360_SH = 26;
    localparam int          QUO360_W    = 8;
    localparam logic [8:0]  DEG_FULL    = 9'd360;

    // Reduced hue 0..359 split into sector and remainder
    localparam int          DEG_W       = 9;
    localparam int          REM_W       = 6;
    localparam logic [10:0] RECIP_SEC   = 11'd1093;
    localparam int          RECIP_SEC_SH = 16;
    localparam logic [REM_W:0] DEG_SECTOR = 7'd60;

    // Channel factor k, 0..60*65536
    localparam int          K_W    = 22;
    localparam logic [K_W-1:0] FULL_K = 22'd3932160;

    // v * k < 2^38; 255 * v * k >> 32 < 2^14
    localparam int PROD_W = 38;
    localparam int N_W    = 14;

    // Divide by 60: floor(n * 17477 / 2^20), exact for n < 23831
    localparam logic [14:0] RECIP60    = 15'd17477;
    localparam int          RECIP60_SH = 20;

    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // Pipeline depth, input beat to output register
    localparam int NSTG = 9;

    typedef enum logic [2:0] {
        SEC_RED_YEL   = 3'd0,
        SEC_YEL_GRN   = 3'd1,
        SEC_GRN_CYN   = 3'd2,
        SEC_CYN_BLU   = 3'd3,
        SEC_BLU_MAG   = 3'd4,
        SEC_MAG_RED   = 3'd5
    } sector_t;

endpackage

`default_nettype wire

[hw/rtl/hsv_to_rgba_pixel_unit.sv]
// HSV to packed RGBA pixel converter, nine-stage pipeline.
// Accepted beats move through stage registers 0 to 8 in order. Throughput: one beat
// per cycle while m_axis_tready is high; each stage has its own valid bit, so bubbles
// collapse and an input beat is taken while a pixel waits if any stage is empty.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline is empty
// and ready once reset is released.
`default_nettype none

module hsv_to_rgba_pixel_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] hue_degrees, [33:16] saturation, [51:34] brightness, [55:52] zero
    input  wire logic [hsvrgb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] pixel_word
    output logic [hsvrgb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int NS = hsvrgb_pkg::NSTG;
    localparam int UW = hsvrgb_pkg::UNIT_W;
    localparam int KW = hsvrgb_pkg::K_W;
    localparam int PW = hsvrgb_pkg::PROD_W;
    localparam int NW = hsvrgb_pkg::N_W;

    // ---------------- flow control ----------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        for (int i = 0; i < NS; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = (i == 0) ? s_axis_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    // ---------------- stage 0: unpack, clamp, bias hue ----------------
    logic signed [hsvrgb_pkg::HUE_W-1:0] hue_in;
    logic signed [hsvrgb_pkg::SV_W-1:0]  sat_in;
    logic signed [hsvrgb_pkg::SV_W-1:0]  bri_in;
    logic [hsvrgb_pkg::HB_W:0]           hue_sum;
    logic [UW-1:0] s0_sat_next, s0_bri_next;
    logic [hsvrgb_pkg::HB_W-1:0] s0_hue_reg;
    logic [UW-1:0] s0_sat_reg, s0_bri_reg;

    assign hue_in = s_axis_tdata[15:0];
    assign sat_in = s_axis_tdata[33:16];
    assign bri_in = s_axis_tdata[51:34];

    assign hue_sum = {{2{hue_in[15]}}, hue_in} + hsvrgb_pkg::HUE_BIAS;

    function automatic logic [hsvrgb_pkg::UNIT_W-1:0] clamp_unit
        (input logic signed [hsvrgb_pkg::SV_W-1:0] x);
        logic [hsvrgb_pkg::UNIT_W-1:0] res;
        if (x[hsvrgb_pkg::SV_W-1])
        begin
            res = '0;
        end
        else if (x[hsvrgb_pkg::SV_W-2:0] > hsvrgb_pkg::UNIT_ONE)
        begin
            res = hsvrgb_pkg::UNIT_ONE;
        end
        else
        begin
            res = x[hsvrgb_pkg::SV_W-2:0];
        end
        return res;
    endfunction

    assign s0_sat_next = clamp_unit(sat_in);
    assign s0_bri_next = clamp_unit(bri_in);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_hue_reg <= hue_sum[hsvrgb_pkg::HB_W-1:0];
            s0_sat_reg <= s0_sat_next;
            s0_bri_reg <= s0_bri_next;
        end
    end

    // ---------------- stage 1: hue / 360 ----------------
    logic [34:0] quo_prod;
    logic [hsvrgb_pkg::HB_W-1:0]    s1_hue_reg;
    logic [hsvrgb_pkg::QUO360_W-1:0] s1_quo_reg;
    logic [UW-1:0] s1_sat_reg, s1_bri_reg;

    assign quo_prod = 35'(s0_hue_reg) * 35'(hsvrgb_pkg::RECIP360);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_hue_reg <= s0_hue_reg;
            s1_quo_reg <= quo_prod[hsvrgb_pkg::RECIP360_SH +: hsvrgb_pkg::QUO360_W];
            s1_sat_reg <= s0_sat_reg;
            s1_bri_reg <= s0_bri_reg;
        end
    end

    // ---------------- stage 2: hue mod 360 ----------------
    logic [hsvrgb_pkg::HB_W-1:0] deg_full;
    logic [hsvrgb_pkg::DEG_W-1:0] s2_deg_reg;
    logic [UW-1:0] s2_sat_reg, s2_bri_reg;

    assign deg_full = s1_hue_reg - 17'(s1_quo_reg) * 17'(hsvrgb_pkg::DEG_FULL);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_deg_reg <= deg_full[hsvrgb_pkg::DEG_W-1:0];
            s2_sat_reg <= s1_sat_reg;
            s2_bri_reg <= s1_bri_reg;
        end
    end

    // ---------------- stage 3: sector and remainder ----------------
    logic [19:0] sec_prod;
    logic [2:0]  sec_idx;
    logic [hsvrgb_pkg::DEG_W-1:0] rem_full;
    hsvrgb_pkg::sector_t s3_sec_reg;
    logic [hsvrgb_pkg::REM_W-1:0] s3_rem_reg;
    logic [UW-1:0] s3_sat_reg, s3_bri_reg;

    assign sec_prod = 20'(s2_deg_reg) * 20'(hsvrgb_pkg::RECIP_SEC);
    assign sec_idx  = sec_prod[hsvrgb_pkg::RECIP_SEC_SH +: 3];
    assign rem_full = s2_deg_reg - 9'(sec_idx) * 9'(hsvrgb_pkg::DEG_SECTOR);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_sec_reg <= hsvrgb_pkg::sector_t'(sec_idx);
            s3_rem_reg <= rem_full[hsvrgb_pkg::REM_W-1:0];
            s3_sat_reg <= s2_sat_reg;
            s3_bri_reg <= s2_bri_reg;
        end
    end

    // ---------------- stage 4: channel factors ----------------
    logic [KW:0]   one_minus_s;
    logic [KW-1:0] kp_next, sr_q, sr_t;
    logic [hsvrgb_pkg::REM_W:0] rem_c;
    hsvrgb_pkg::sector_t s4_sec_reg;
    logic [KW-1:0] s4_kp_reg, s4_kq_reg, s4_kt_reg;
    logic [UW-1:0] s4_bri_reg;

    assign one_minus_s = 23'(hsvrgb_pkg::UNIT_ONE) - 23'(s3_sat_reg);
    assign kp_next     = KW'(one_minus_s * 23'(hsvrgb_pkg::DEG_SECTOR));
    assign rem_c       = hsvrgb_pkg::DEG_SECTOR - 7'(s3_rem_reg);
    assign sr_q        = KW'(23'(s3_sat_reg) * 23'(s3_rem_reg));
    assign sr_t        = KW'(23'(s3_sat_reg) * 23'(rem_c));

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_sec_reg <= s3_sec_reg;
            s4_kp_reg  <= kp_next;
            s4_kq_reg  <= hsvrgb_pkg::FULL_K - sr_q;
            s4_kt_reg  <= hsvrgb_pkg::FULL_K - sr_t;
            s4_bri_reg <= s3_bri_reg;
        end
    end

    // ---------------- stage 5: v * k, v * 255 >> 16 ----------------
    logic [23:0] cv_prod;
    hsvrgb_pkg::sector_t s5_sec_reg;
    logic [PW-1:0] s5_pp_reg, s5_pq_reg, s5_pt_reg;
    logic [7:0]    s5_cv_reg;

    assign cv_prod = 24'(s4_bri_reg) * 24'(hsvrgb_pkg::CHAN_MAX);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_sec_reg <= s4_sec_reg;
            s5_pp_reg  <= PW'(39'(s4_bri_reg) * 39'(s4_kp_reg));
            s5_pq_reg  <= PW'(39'(s4_bri_reg) * 39'(s4_kq_reg));
            s5_pt_reg  <= PW'(39'(s4_bri_reg) * 39'(s4_kt_reg));
            s5_cv_reg  <= cv_prod[23:16];
        end
    end

    // ---------------- stage 6: times 255, drop 2^32 ----------------
    logic [PW+7:0] wp, wq, wt;
    hsvrgb_pkg::sector_t s6_sec_reg;
    logic [NW-1:0] s6_np_reg, s6_nq_reg, s6_nt_reg;
    logic [7:0]    s6_cv_reg;

    assign wp = {s5_pp_reg, 8'd0} - (PW+8)'(s5_pp_reg);
    assign wq = {s5_pq_reg, 8'd0} - (PW+8)'(s5_pq_reg);
    assign wt = {s5_pt_reg, 8'd0} - (PW+8)'(s5_pt_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_sec_reg <= s5_sec_reg;
            s6_np_reg  <= wp[32 +: NW];
            s6_nq_reg  <= wq[32 +: NW];
            s6_nt_reg  <= wt[32 +: NW];
            s6_cv_reg  <= s5_cv_reg;
        end
    end

    // ---------------- stage 7: divide by 60 ----------------
    logic [28:0] dp, dq, dt;
    hsvrgb_pkg::sector_t s7_sec_reg;
    logic [7:0] s7_cp_reg, s7_cq_reg, s7_ct_reg, s7_cv_reg;

    assign dp = 29'(s6_np_reg) * 29'(hsvrgb_pkg::RECIP60);
    assign dq = 29'(s6_nq_reg) * 29'(hsvrgb_pkg::RECIP60);
    assign dt = 29'(s6_nt_reg) * 29'(hsvrgb_pkg::RECIP60);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_sec_reg <= s6_sec_reg;
            s7_cp_reg  <= dp[hsvrgb_pkg::RECIP60_SH +: 8];
            s7_cq_reg  <= dq[hsvrgb_pkg::RECIP60_SH +: 8];
            s7_ct_reg  <= dt[hsvrgb_pkg::RECIP60_SH +: 8];
            s7_cv_reg  <= s6_cv_reg;
        end
    end

    // ---------------- stage 8: sector select, pack ----------------
    logic [7:0] red, green, blue;
    logic [hsvrgb_pkg::OUT_TDATA_W-1:0] pix_reg;

    always_comb
    begin
        case (s7_sec_reg)
            hsvrgb_pkg::SEC_YEL_GRN:
            begin
                red = s7_cq_reg; green = s7_cv_reg; blue = s7_cp_reg;
            end
            hsvrgb_pkg::SEC_GRN_CYN:
            begin
                red = s7_cp_reg; green = s7_cv_reg; blue = s7_ct_reg;
            end
            hsvrgb_pkg::SEC_CYN_BLU:
            begin
                red = s7_cp_reg; green = s7_cq_reg; blue = s7_cv_reg;
            end
            hsvrgb_pkg::SEC_BLU_MAG:
            begin
                red = s7_ct_reg; green = s7_cp_reg; blue = s7_cv_reg;
            end
            hsvrgb_pkg::SEC_MAG_RED:
            begin
                red = s7_cv_reg; green = s7_cp_reg; blue = s7_cq_reg;
            end
            default:
            begin
                red = s7_cv_reg; green = s7_ct_reg; blue = s7_cp_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            pix_reg <= {red, green, blue, hsvrgb_pkg::CHAN_MAX};
        end
    end

    assign m_axis_tdata = pix_reg;

endmodule

`default_nettype wire

[hw/rtl/hsvrgb_checker.sv]
// Port-level checker for the HSV to RGBA pixel converter, with its bind.
`default_nettype none

module hsvrgb_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [hsvrgb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // output beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // alpha byte is always opaque
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] == hsvrgb_pkg::CHAN_MAX)
        else $error("alpha byte not 0xFF");

    // a free-running sink never backs up the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is drained");

    // pipeline is empty coming out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    logic unused_in;
    assign unused_in = s_axis_tvalid;

endmodule

bind hsv_to_rgba_pixel_unit hsvrgb_checker u_hsvrgb_checker (.*);

`default_nettype wire
